// ----- rtl/rss_pkg.sv -----
// Shared types, constants and command codes of the RMS smooth sensitivity core.
`default_nettype none
package rss_pkg;

    localparam int ERR_W         = 24;
    localparam int BOUND_W       = 23;
    localparam int DECAY_W       = 16;
    localparam int WGT_W         = 17;
    localparam int SQ_W          = 46;
    localparam int CFG_W         = 23;
    localparam int OUT_W         = 23;
    localparam int CNT_OUT_W     = 11;
    localparam int MAX_ITEMS_DEF = 1024;

    localparam logic [BOUND_W-1:0] BOUND_RST = 23'd65536;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'hFFFF;
    localparam logic [WGT_W-1:0]   WGT_ONE   = 17'h10000;

    // Configuration register indexes.
    localparam logic CFG_IDX_BOUND = 1'b0;
    localparam logic CFG_IDX_DECAY = 1'b1;

    // Operand selects for the quotient-root unit.
    localparam logic [2:0] SEL_TOTAL   = 3'd0;
    localparam logic [2:0] SEL_PRE_OLD = 3'd1;
    localparam logic [2:0] SEL_PRE_NEW = 3'd2;
    localparam logic [2:0] SEL_SUF_OLD = 3'd3;
    localparam logic [2:0] SEL_SUF_NEW = 3'd4;

    typedef struct packed {
        logic signed [ERR_W-1:0] error_value;
        logic                    last_item;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0]     rms_value;
        logic [OUT_W-1:0]     sens_value;
        logic [CNT_OUT_W-1:0] item_count;
        logic                 overflowed;
    } out_beat_t;

    typedef struct packed {
        logic       load;
        logic       ins_rd;
        logic       ins_shift;
        logic       ins_put;
        logic       fin_init;
        logic       q_start;
        logic       q_save;
        logic       rd_hi;
        logic       rd_lo;
        logic       cap_large;
        logic       upd;
        logic       acc;
        logic       best;
        logic       out_load;
        logic [2:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
        logic j_zero;
        logic rd_gt;
        logic q_done;
        logic cnt_zero;
        logic k_last;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/rss_qroot.sv -----
// Iterative unit computing floor(sqrt(floor(num / den))), one bit per cycle.
`default_nettype none
module rss_qroot
    import rss_pkg::*;
#(
    parameter int NUM_W = 58,
    parameter int DEN_W = 11
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [NUM_W-1:0]         num,
    input  wire logic [DEN_W-1:0]         den,
    output logic                          busy,
    output logic                          done,
    output logic [(NUM_W+1)/2-1:0]        root
);
    localparam int RT_W  = (NUM_W + 1) / 2;
    localparam int RAD_W = 2 * RT_W;
    localparam int CT_W  = $clog2(RAD_W + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    logic [1:0]       ph_reg;
    logic [CT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0] acc_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [RT_W+1:0]  srem_reg;
    logic [RT_W-1:0]  root_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [RAD_W-1:0] div_shift;
    logic [RT_W+3:0]  srem_sh;
    logic [RT_W+3:0]  trial;
    logic             sge;
    logic [RT_W+3:0]  srem_diff;

    assign rem_sh    = {rem_reg, acc_reg[NUM_W-1]};
    assign ge        = rem_sh >= {1'b0, den_reg};
    assign div_shift = {acc_reg[RAD_W-2:0], ge};

    assign srem_sh   = {srem_reg, acc_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign sge       = srem_sh >= trial;
    assign srem_diff = srem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (ph_reg)
                PH_IDLE: begin
                    if (start) begin
                        ph_reg <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    if (cnt_reg == '0) begin
                        ph_reg <= PH_SQRT;
                    end
                end
                PH_SQRT: begin
                    if (cnt_reg == '0) begin
                        ph_reg   <= PH_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default: ph_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ph_reg)
            PH_IDLE: begin
                if (start) begin
                    acc_reg <= RAD_W'(num);
                    den_reg <= den;
                    rem_reg <= '0;
                    cnt_reg <= CT_W'(NUM_W - 1);
                end
            end
            PH_DIV: begin
                acc_reg <= RAD_W'(div_shift[NUM_W-1:0]);
                rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                if (cnt_reg == '0) begin
                    cnt_reg  <= CT_W'(RT_W - 1);
                    srem_reg <= '0;
                    root_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg - CT_W'(1);
                end
            end
            PH_SQRT: begin
                acc_reg  <= {acc_reg[RAD_W-3:0], 2'b00};
                srem_reg <= sge ? srem_diff[RT_W+1:0] : srem_sh[RT_W+1:0];
                root_reg <= {root_reg[RT_W-2:0], sge};
                cnt_reg  <= cnt_reg - CT_W'(1);
            end
            default: ;
        endcase
    end

    assign busy = ph_reg != PH_IDLE;
    assign done = done_reg;
    assign root = root_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done)
        else $error("quotient-root done held for more than one cycle");

endmodule
`default_nettype wire

// ----- rtl/rss_dp.sv -----
// Datapath: configuration, sorted square store, running sums and sensitivity search.
`default_nettype none
module rss_dp
    import rss_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire in_beat_t         s_data,
    input  wire dp_cmd_t          cmd,
    output dp_sts_t               sts,
    output out_beat_t             out_data
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = SQ_W + CW + 1;
    localparam int RW = (SW + 1) / 2;
    localparam int PW = RW + WGT_W;
    localparam int BW = PW - 16;

    logic [BOUND_W-1:0] bound_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic [CW-1:0]   count_reg;
    logic [SW-1:0]   total_reg;
    logic            drop_reg;
    logic            skip_reg;
    logic            last_reg;
    logic [CW-1:0]   j_reg;
    logic [SQ_W-1:0] v_reg;

    logic [SQ_W-1:0] mem [MAX_ITEMS];
    logic [SQ_W-1:0] rd_data_reg;

    logic [SQ_W-1:0]  usq_reg;
    logic [SW-1:0]    prefix_reg;
    logic [SW-1:0]    suffix_reg;
    logic [SW-1:0]    opa_reg;
    logic [SW-1:0]    opc_reg;
    logic [SQ_W-1:0]  largest_reg;
    logic [WGT_W-1:0] w_reg;
    logic [CW-1:0]    lo_reg;
    logic [RW-1:0]    rms_reg;
    logic [RW-1:0]    ra_reg;
    logic [RW-1:0]    rb_reg;
    logic [RW-1:0]    rc_reg;
    logic [RW-1:0]    rd_reg;
    logic [PW-1:0]    prod_reg;
    logic [BW-1:0]    best_reg;
    out_beat_t        out_reg;

    logic [ERR_W-1:0]         err_u;
    logic [ERR_W-1:0]         mag_full;
    logic [BOUND_W-1:0]       mag;
    logic [SQ_W-1:0]          sq;
    logic                     room;
    logic [CW-1:0]            jm1;
    logic [CW-1:0]            hi_full;
    logic [AW-1:0]            rd_addr;
    logic                     rd_en;
    logic                     wr_en;
    logic [SQ_W-1:0]          wr_data;
    logic [WGT_W+DECAY_W-1:0] wprod;
    logic [RW-1:0]            pl;
    logic [RW-1:0]            sl;
    logic [RW-1:0]            loc;
    logic [BW-1:0]            weighted;
    logic [SW-1:0]            q_num;
    logic [CW-1:0]            q_den;
    logic                     q_busy;
    logic                     q_done;
    logic [RW-1:0]            q_root;

    assign err_u    = s_data.error_value;
    assign mag_full = err_u[ERR_W-1] ? (~err_u + ERR_W'(1)) : err_u;
    assign mag      = (mag_full > {1'b0, bound_reg}) ? bound_reg : mag_full[BOUND_W-1:0];
    assign sq       = mag * mag;
    assign room     = count_reg < CW'(MAX_ITEMS);

    assign jm1      = j_reg - CW'(1);
    assign hi_full  = count_reg - CW'(1) - lo_reg;
    assign rd_addr  = cmd.rd_hi ? hi_full[AW-1:0] : (cmd.rd_lo ? lo_reg[AW-1:0] : jm1[AW-1:0]);
    assign rd_en    = cmd.ins_rd | cmd.rd_hi | cmd.rd_lo;
    assign wr_en    = cmd.ins_shift | cmd.ins_put;
    assign wr_data  = cmd.ins_shift ? rd_data_reg : v_reg;

    assign wprod    = w_reg * decay_reg;
    assign pl       = (ra_reg > rb_reg) ? ra_reg - rb_reg : rb_reg - ra_reg;
    assign sl       = (rc_reg > rd_reg) ? rc_reg - rd_reg : rd_reg - rc_reg;
    assign loc      = (pl > sl) ? pl : sl;
    assign weighted = prod_reg[PW-1:16];
    assign q_den    = (count_reg == '0) ? CW'(1) : count_reg;

    always_comb begin
        case (cmd.sel)
            SEL_PRE_OLD: q_num = opa_reg;
            SEL_PRE_NEW: q_num = prefix_reg;
            SEL_SUF_OLD: q_num = opc_reg;
            SEL_SUF_NEW: q_num = suffix_reg;
            default:     q_num = total_reg;
        endcase
    end

    rss_qroot #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_qroot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.q_start),
        .num     (q_num),
        .den     (q_den),
        .busy    (q_busy),
        .done    (q_done),
        .root    (q_root)
    );

    // Square store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[j_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= BOUND_RST;
            decay_reg <= DECAY_RST;
            count_reg <= '0;
            total_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_IDX_BOUND: bound_reg <= cfg_wdata[BOUND_W-1:0];
                    CFG_IDX_DECAY: decay_reg <= cfg_wdata[DECAY_W-1:0];
                endcase
            end
            if (cmd.out_load) begin
                count_reg <= '0;
                total_reg <= '0;
                drop_reg  <= 1'b0;
            end else if (cmd.load) begin
                if (room) begin
                    count_reg <= count_reg + CW'(1);
                    total_reg <= total_reg + SW'(sq);
                end else begin
                    drop_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg    <= sq;
            j_reg    <= count_reg;
            skip_reg <= !room;
            last_reg <= s_data.last_item;
        end
        if (cmd.ins_shift) begin
            j_reg <= jm1;
        end
        if (cmd.fin_init) begin
            usq_reg    <= bound_reg * bound_reg;
            prefix_reg <= total_reg;
            suffix_reg <= total_reg;
            w_reg      <= WGT_ONE;
            best_reg   <= '0;
            lo_reg     <= '0;
        end
        if (cmd.cap_large) begin
            largest_reg <= rd_data_reg;
        end
        if (cmd.upd) begin
            opa_reg    <= prefix_reg;
            prefix_reg <= prefix_reg - SW'(largest_reg);
            opc_reg    <= suffix_reg;
            suffix_reg <= suffix_reg - SW'(rd_data_reg) + SW'(usq_reg);
            w_reg      <= wprod[WGT_W+DECAY_W-1:16];
        end
        if (cmd.q_save) begin
            case (cmd.sel)
                SEL_PRE_OLD: ra_reg  <= q_root;
                SEL_PRE_NEW: rb_reg  <= q_root;
                SEL_SUF_OLD: rc_reg  <= q_root;
                SEL_SUF_NEW: rd_reg  <= q_root;
                default:     rms_reg <= q_root;
            endcase
        end
        if (cmd.acc) begin
            prod_reg <= loc * w_reg;
        end
        if (cmd.best) begin
            if (weighted > best_reg) begin
                best_reg <= weighted;
            end
            lo_reg <= lo_reg + CW'(1);
        end
        if (cmd.out_load) begin
            out_reg.rms_value  <= OUT_W'(rms_reg);
            out_reg.sens_value <= OUT_W'(best_reg);
            out_reg.item_count <= CNT_OUT_W'(count_reg);
            out_reg.overflowed <= drop_reg;
        end
    end

    assign sts.skip     = skip_reg;
    assign sts.last     = last_reg;
    assign sts.j_zero   = j_reg == '0;
    assign sts.rd_gt    = rd_data_reg > v_reg;
    assign sts.q_done   = q_done;
    assign sts.cnt_zero = count_reg == '0;
    assign sts.k_last   = (lo_reg + CW'(1)) == count_reg;
    assign out_data     = out_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ITEMS))
        else $error("stored count exceeds the store depth");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.q_start |-> !q_busy)
        else $error("quotient-root started while busy");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && room |=> count_reg == $past(count_reg) + CW'(1))
        else $error("stored count did not advance on a stored beat");

endmodule
`default_nettype wire

// ----- rtl/rss_ctrl.sv -----
// Controller: sequences loading, insertion sort and the sensitivity search.
`default_nettype none
module rss_ctrl
    import rss_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INS  = 4'd1;
    localparam logic [3:0] ST_CMP  = 4'd2;
    localparam logic [3:0] ST_FIN  = 4'd3;
    localparam logic [3:0] ST_QST  = 4'd4;
    localparam logic [3:0] ST_QWT  = 4'd5;
    localparam logic [3:0] ST_RDH  = 4'd6;
    localparam logic [3:0] ST_RDL  = 4'd7;
    localparam logic [3:0] ST_UPD  = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_BEST = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] sel_reg;
    logic [2:0] sel_next;
    logic       m_valid_reg;
    logic [3:0] end_state;

    assign end_state = sts.last ? ST_FIN : ST_IDLE;

    always_comb begin
        cmd        = '0;
        cmd.sel    = sel_reg;
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                if (sts.skip) begin
                    state_next = end_state;
                end else if (sts.j_zero) begin
                    cmd.ins_put = 1'b1;
                    state_next  = end_state;
                end else begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (sts.rd_gt) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS;
                end else begin
                    cmd.ins_put = 1'b1;
                    state_next  = end_state;
                end
            end
            ST_FIN: begin
                cmd.fin_init = 1'b1;
                sel_next     = SEL_TOTAL;
                state_next   = ST_QST;
            end
            ST_QST: begin
                cmd.q_start = 1'b1;
                state_next  = ST_QWT;
            end
            ST_QWT: begin
                if (sts.q_done) begin
                    cmd.q_save = 1'b1;
                    if (sel_reg == SEL_TOTAL) begin
                        state_next = sts.cnt_zero ? ST_OUT : ST_RDH;
                    end else if (sel_reg == SEL_SUF_NEW) begin
                        state_next = ST_ACC;
                    end else begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = ST_QST;
                    end
                end
            end
            ST_RDH: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RDL;
            end
            ST_RDL: begin
                cmd.rd_lo     = 1'b1;
                cmd.cap_large = 1'b1;
                state_next    = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                sel_next   = SEL_PRE_OLD;
                state_next = ST_QST;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_BEST;
            end
            ST_BEST: begin
                cmd.best   = 1'b1;
                state_next = sts.k_last ? ST_OUT : ST_RDH;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= SEL_TOTAL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ----- rtl/rms_smooth_sensitivity_core.sv -----
// Top level of the RMS smooth sensitivity core: controller plus datapath.
//
// Error terms arrive one beat at a time on the s_ channel (signed Q8.16 with a
// last_item marker). Each beat is clamped to the error bound, squared and
// insertion-sorted into an on-chip store: after the load, each stored square
// larger than it is read, compared and moved up one place, and then the beat
// is written in. Beats beyond MAX_ITEMS are dropped and flagged. After the
// beat that carries last_item, the block computes the floor-root RMS and the
// beta-smooth sensitivity. One shared quotient-root unit (one bit per cycle)
// sets the pace: it runs once for the RMS and four times per stored item. The
// result beat is then held in an output register on the m_ channel until taken;
// the next set may already load while it waits, but a following result waits
// for the receiver. s_ready is low while sorting or computing. Configuration is
// written through cfg_wr_en, cfg_index and cfg_wdata (index 0 error bound,
// index 1 decay factor). A synchronous reset restores the register defaults
// and empties the set; the store itself is not cleared, as only written
// entries are ever read.
`default_nettype none
module rms_smooth_sensitivity_core
    import rss_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_beat_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_beat_t             m_data
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller only issues commands; all arithmetic and storage sits in
    // the datapath.
    rss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rss_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire
